>>> hdl/assert_macros.svh
// Assertion macros shared by the ASCII85 encoder RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define A85_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a precondition implies a consequence in the same cycle.
`define A85_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Check that a precondition implies a consequence in the next cycle.
`define A85_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/a85_pkg.sv
// Package of the ASCII85 stream encoder: character codes, base-85 constants,
// job and queue types, emitter phases. No dependencies.
`default_nettype none

package a85_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] CharLt      = 8'h3C;
  localparam logic [7:0] CharTilde   = 8'h7E;
  localparam logic [7:0] CharGt      = 8'h3E;
  localparam logic [7:0] CharZero    = 8'h7A;
  localparam logic [7:0] DigitOffset = 8'h21;

  localparam int unsigned DigitCount = 5;
  localparam logic [2:0]  NumDigits  = 3'(DigitCount);
  localparam logic [31:0] Base       = 32'd85;

  // floor(v / 85) == (v * RecipMagic) >> RecipShift for every 32-bit v
  localparam logic [31:0] RecipMagic = 32'hC0C0C0C1;
  localparam int unsigned RecipShift = 38;
  localparam int unsigned QuoW       = 64 - RecipShift;

  typedef struct packed {
    logic        opener;
    logic        zero_grp;
    logic [2:0]  ndig;
    logic        closer;
    logic [31:0] word;
  } a85_job_t;

  typedef struct packed {
    logic     push;
    a85_job_t job;
  } a85_push_t;

  typedef enum logic [2:0] {
    PhOpenLt,
    PhOpenTl,
    PhZero,
    PhDigit,
    PhCloseTl,
    PhCloseGt
  } a85_phase_e;

endpackage

`default_nettype wire

>>> hdl/a85_stream_if.sv
// Valid/ready stream interfaces of the ASCII85 encoder: input bytes and
// output characters. No dependencies.
`default_nettype none

interface a85_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface a85_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_run;

  modport source (output valid, output text_char, output end_of_run, input ready);
  modport sink (input valid, input text_char, input end_of_run, output ready);
endinterface

`default_nettype wire

>>> hdl/a85_fifo.sv
// Job queue between the byte front end and the encoding back end.
// Depends on a85_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module a85_fifo #(
  parameter int unsigned Depth = a85_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  a85_pkg::a85_push_t push_i,
  output logic               full_o,
  output logic               valid_o,
  output a85_pkg::a85_job_t  job_o,
  input  logic               pop_i
);
  import a85_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  a85_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i.push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    case ({push_i.push, do_pop})
      2'b10:   cnt_d = CntW'(cnt_q + 1'b1);
      2'b01:   cnt_d = CntW'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  `A85_ASSERT(a_fifo_cnt_range, cnt_q <= FullCnt, "queue count above depth")
  `A85_ASSERT_IMPL(a_fifo_no_overflow, push_i.push, !full_o, "push into full queue")

endmodule

`default_nettype wire

>>> hdl/a85_front.sv
// Front end: accepts bytes, packs groups and turns them into encoding
// jobs. Depends on a85_pkg, a85_stream_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module a85_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  a85_byte_if.sink           byte_in_i,
  input  logic               q_full_i,
  output a85_pkg::a85_push_t push_o
);
  import a85_pkg::*;

  logic [31:0] grp_q, grp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        open_q, open_d;
  logic [31:0] ins_word;
  logic [31:0] word_new;
  logic        accept;
  logic        grp_full;
  logic        last;

  assign byte_in_i.ready = !q_full_i;
  assign accept          = byte_in_i.valid && byte_in_i.ready;
  assign last            = byte_in_i.last_byte;
  assign grp_full        = (cnt_q == 2'd3);
  assign word_new        = grp_q | ins_word;

  always_comb begin
    case (cnt_q)
      2'd0:    ins_word = {byte_in_i.data_byte, 24'b0};
      2'd1:    ins_word = {8'b0, byte_in_i.data_byte, 16'b0};
      2'd2:    ins_word = {16'b0, byte_in_i.data_byte, 8'b0};
      default: ins_word = {24'b0, byte_in_i.data_byte};
    endcase
  end

  always_comb begin
    push_o.job.opener   = !open_q;
    push_o.job.closer   = last;
    push_o.job.word     = word_new;
    push_o.job.zero_grp = grp_full && (word_new == '0);
    if (grp_full) begin
      push_o.job.ndig = (word_new == '0) ? 3'd0 : NumDigits;
    end else if (last) begin
      push_o.job.ndig = {1'b0, cnt_q} + 3'd2;
    end else begin
      push_o.job.ndig = 3'd0;
    end
    push_o.push = accept && (!open_q || grp_full || last);

    grp_d  = grp_q;
    cnt_d  = cnt_q;
    open_d = open_q;
    if (accept) begin
      open_d = !last;
      if (grp_full || last) begin
        grp_d = '0;
        cnt_d = '0;
      end else begin
        grp_d = word_new;
        cnt_d = 2'(cnt_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q  <= '0;
      cnt_q  <= '0;
      open_q <= 1'b0;
    end else begin
      grp_q  <= grp_d;
      cnt_q  <= cnt_d;
      open_q <= open_d;
    end
  end

  `A85_ASSERT_NEXT(a_front_clear_on_last, accept && last,
                   (cnt_q == 2'd0) && (grp_q == '0) && !open_q, "state not cleared after last")

endmodule

`default_nettype wire

>>> hdl/a85_back.sv
// Back end: base-85 digit converter and character emitter with output
// register. Depends on a85_pkg, a85_stream_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module a85_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  a85_pkg::a85_job_t q_job_i,
  output logic              q_pop_o,
  a85_char_if.source        char_out_o
);
  import a85_pkg::*;

  // converter
  logic            cv_valid_q;
  a85_job_t        cv_job_q;
  logic [2:0]      cv_cnt_q;
  logic [31:0]     cv_v_q;
  logic [63:0]     cv_p_q;
  logic [6:0]      cv_dig_q [DigitCount];
  logic [QuoW-1:0] quo;
  logic [6:0]      rem;
  logic [31:0]     mul_a;
  logic [63:0]     prod;
  logic            cv_step;
  logic            cv_done;
  logic            handoff;

  // emitter
  logic            em_valid_q;
  a85_job_t        em_job_q;
  logic [6:0]      em_dig_q [DigitCount];
  a85_phase_e      em_ph_q, ph_nxt, ph_start;
  logic [2:0]      em_idx_q, idx_nxt;
  logic [7:0]      em_char;
  logic            em_last;
  logic            em_finish;
  logic            out_load;

  // output register
  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            out_end_q;

  assign quo     = cv_p_q[63:RecipShift];
  assign rem     = 7'(cv_v_q - (32'(quo) * Base));
  assign mul_a   = q_pop_o ? q_job_i.word : 32'(quo);
  assign prod    = {32'b0, mul_a} * {32'b0, RecipMagic};
  assign cv_step = cv_valid_q && (cv_cnt_q != NumDigits);
  assign cv_done = cv_valid_q && (cv_cnt_q == NumDigits);

  assign out_load  = em_valid_q && (!out_valid_q || char_out_o.ready);
  assign em_finish = out_load && em_last;
  assign handoff   = cv_done && (!em_valid_q || em_finish);
  assign q_pop_o   = q_valid_i && (!cv_valid_q || handoff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_valid_q <= 1'b0;
      cv_cnt_q   <= '0;
    end else if (q_pop_o) begin
      cv_valid_q <= 1'b1;
      cv_cnt_q   <= (q_job_i.ndig == 3'd0) ? NumDigits : 3'd0;
    end else if (handoff) begin
      cv_valid_q <= 1'b0;
    end else if (cv_step) begin
      cv_cnt_q <= 3'(cv_cnt_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cv_job_q <= q_job_i;
      cv_v_q   <= q_job_i.word;
      cv_p_q   <= prod;
    end else if (cv_step) begin
      cv_v_q   <= 32'(quo);
      cv_p_q   <= prod;
      cv_dig_q[3'(NumDigits - 3'd1 - cv_cnt_q)] <= rem;
    end
  end

  always_comb begin
    if (cv_job_q.opener) begin
      ph_start = PhOpenLt;
    end else if (cv_job_q.zero_grp) begin
      ph_start = PhZero;
    end else if (cv_job_q.ndig != 3'd0) begin
      ph_start = PhDigit;
    end else begin
      ph_start = PhCloseTl;
    end
  end

  always_comb begin
    ph_nxt  = em_ph_q;
    idx_nxt = em_idx_q;
    em_last = 1'b0;
    em_char = CharGt;
    case (em_ph_q)
      PhOpenLt: begin
        em_char = CharLt;
        ph_nxt  = PhOpenTl;
      end
      PhOpenTl: begin
        em_char = CharTilde;
        if (em_job_q.zero_grp) begin
          ph_nxt = PhZero;
        end else if (em_job_q.ndig != 3'd0) begin
          ph_nxt = PhDigit;
        end else if (em_job_q.closer) begin
          ph_nxt = PhCloseTl;
        end else begin
          em_last = 1'b1;
        end
      end
      PhZero: begin
        em_char = CharZero;
        if (em_job_q.closer) begin
          ph_nxt = PhCloseTl;
        end else begin
          em_last = 1'b1;
        end
      end
      PhDigit: begin
        em_char = {1'b0, em_dig_q[em_idx_q]} + DigitOffset;
        if (3'(em_idx_q + 3'd1) != em_job_q.ndig) begin
          idx_nxt = 3'(em_idx_q + 3'd1);
        end else if (em_job_q.closer) begin
          ph_nxt = PhCloseTl;
        end else begin
          em_last = 1'b1;
        end
      end
      PhCloseTl: begin
        em_char = CharTilde;
        ph_nxt  = PhCloseGt;
      end
      PhCloseGt: begin
        em_char = CharGt;
        em_last = 1'b1;
      end
      default: begin
        em_char = CharGt;
        em_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
      em_ph_q    <= PhOpenLt;
      em_idx_q   <= '0;
    end else if (handoff) begin
      em_valid_q <= 1'b1;
      em_ph_q    <= ph_start;
      em_idx_q   <= '0;
    end else if (em_finish) begin
      em_valid_q <= 1'b0;
    end else if (out_load) begin
      em_ph_q  <= ph_nxt;
      em_idx_q <= idx_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (handoff) begin
      em_job_q <= cv_job_q;
      em_dig_q <= cv_dig_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (char_out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q <= em_char;
      out_end_q  <= em_last;
    end
  end

  assign char_out_o.valid      = out_valid_q;
  assign char_out_o.text_char  = out_char_q;
  assign char_out_o.end_of_run = out_end_q;

  `A85_ASSERT(a_back_cnt_range, cv_cnt_q <= NumDigits, "converter count out of range")
  `A85_ASSERT_IMPL(a_back_dig_idx, em_valid_q && (em_ph_q == PhDigit),
                   (em_idx_q < em_job_q.ndig) && (em_job_q.ndig <= NumDigits),
                   "digit index beyond digit count")

endmodule

`default_nettype wire

>>> hdl/ascii85_stream_encoder_top.sv
// ASCII85 stream encoder. Bytes enter on byte_in_i one per cycle while the job
// queue has room; characters leave on char_out_o from a registered output, one
// per cycle while a group is ready to emit and the sink takes them. A full
// nonzero group passes through the base-85 converter (a load, then one digit
// per cycle through a single 32x32 reciprocal multiplier), overlapped with
// emission of the previous group, and the output channel carries five
// characters per four bytes; an all-zero group costs one character. Depends
// on a85_pkg, a85_stream_if, a85_fifo, a85_front and a85_back.
`default_nettype none

module ascii85_stream_encoder_top #(
  parameter int unsigned QueueDepth = a85_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  a85_byte_if.sink   byte_in_i,
  a85_char_if.source char_out_o
);
  import a85_pkg::*;

  a85_push_t push;
  a85_job_t  q_job;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;

  a85_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_in_i (byte_in_i),
    .q_full_i  (q_full),
    .push_o    (push)
  );

  a85_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (q_job),
    .pop_i   (q_pop)
  );

  a85_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (q_job),
    .q_pop_o    (q_pop),
    .char_out_o (char_out_o)
  );

endmodule

`default_nettype wire
